// File: src/tlpq_pkg.sv
// Package for the three level priority queue: sizes, codes and shared types.
`default_nettype none

package tlpq_pkg;

   // Default sizes
   localparam int QUEUE_DEPTH = 64;
   localparam int TAG_BITS    = 16;

   // Request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Priority levels
   localparam logic [2:0] LVL_URGENT = 3'd1;
   localparam logic [2:0] LVL_MIDDLE = 3'd2;
   localparam logic [2:0] LVL_NORMAL = 3'd3;

   // Response status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REMOVED  = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // Decision taken by the controller for one request beat.
   typedef struct packed {
      logic       mem_en;
      logic       mem_we;
      logic [2:0] status;
      logic [1:0] level;
   } op_type;

endpackage

`default_nettype wire

// File: src/tlpq_if.sv
// Request and response channel interfaces of the three level priority queue.
`default_nettype none

interface tlpq_req_if #(
   parameter int TagBits = tlpq_pkg::TAG_BITS
);
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [TagBits-1:0] patient_tag;
   logic [2:0]         priority_level;

   modport source (output valid, req_type, patient_tag, priority_level, input ready);
   modport sink   (input valid, req_type, patient_tag, priority_level, output ready);
endinterface

interface tlpq_rsp_if #(
   parameter int TagBits = tlpq_pkg::TAG_BITS
);
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [TagBits-1:0] out_tag;
   logic [1:0]         out_level;

   modport source (output valid, status, out_tag, out_level, input ready);
   modport sink   (input valid, status, out_tag, out_level, output ready);
endinterface

`default_nettype wire

// File: src/three_level_priority_queue.sv
// Top level of the three level priority queue, with the tag memory and response register.
// An insert, refusal or empty answer is presented in the cycle after its request beat;
// a removal after the registered tag memory read and then the response register.
// One insert-type request per cycle while responses are taken; a removal blocks new beats.
// Reset clears the level counters, ring heads and response valid; the tag memory is not cleared.
`default_nettype none

module three_level_priority_queue #(
   parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH,
   parameter int TAG_BITS    = tlpq_pkg::TAG_BITS
) (
   input wire logic   clock,
   input wire logic   reset,
   tlpq_req_if.sink   req_chan,
   tlpq_rsp_if.source rsp_chan
);

   localparam int MAW = $clog2(3 * QUEUE_DEPTH);

   localparam logic StIdle = 1'b0;
   localparam logic StRead = 1'b1;

   logic                state_ff,      state_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0] rsp_tag_ff,    rsp_tag_in;
   logic [1:0]          rsp_level_ff,  rsp_level_in;

   logic                req_ready;
   logic                accept;
   tlpq_pkg::op_type    op;
   logic [MAW-1:0]      mem_addr;
   logic [TAG_BITS-1:0] rd_data;

   // A new beat is taken when no removal is in flight and the response slot frees.
   assign req_ready      = (state_ff == StIdle) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   tlpq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_chan.req_type),
      .priority_level (req_chan.priority_level),
      .op             (op),
      .mem_addr       (mem_addr)
   );

   tlpq_ram #(
      .Width (TAG_BITS),
      .Depth (3 * QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (accept && op.mem_en),
      .we    (op.mem_we),
      .addr  (mem_addr),
      .wdata (req_chan.patient_tag),
      .rdata (rd_data)
   );

   // Response register: loaded at the beat, or in the cycle after it with the read tag.
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_level_in  = rsp_level_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               rsp_status_in = op.status;
               rsp_level_in  = op.level;
               rsp_tag_in    = '0;
               if (op.mem_en && !op.mem_we) begin
                  state_in = StRead;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         StRead: begin
            rsp_tag_in   = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.out_tag   = rsp_tag_ff;
   assign rsp_chan.out_level = rsp_level_ff;

   // A removal beat waits in the read state for its tag, then presents it in the cycle after.
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == StRead |=> state_ff == StIdle && rsp_valid_ff)
      else $error("removal did not complete one cycle after its read");

   // While a read is in flight the response slot is empty.
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == StRead |-> !rsp_valid_ff)
      else $error("response still pending during a tag read");

   // Only a removal carries a tag and a level.
   a_non_removal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != tlpq_pkg::ST_REMOVED |->
         rsp_tag_ff == '0 && rsp_level_ff == '0)
      else $error("non removal response carries a tag or level");

   // An accepted removal from a non empty queue starts a memory read.
   a_removal_reads: assert property (@(posedge clock) disable iff (reset)
      accept && op.status == tlpq_pkg::ST_REMOVED |=> state_ff == StRead)
      else $error("removal beat did not start a tag read");

endmodule

`default_nettype wire

// File: src/tlpq_ram.sv
// Generic single port RAM with a registered read.
`default_nettype none

module tlpq_ram #(
   parameter int Width = tlpq_pkg::TAG_BITS,
   parameter int Depth = 3 * tlpq_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   // One access per cycle: a write, or a read whose data appears next cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/tlpq_ctrl.sv
// Queue controller: level counters, ring heads and tag memory addressing.
`default_nettype none

module tlpq_ctrl #(
   parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH,
   localparam int AW  = $clog2(QUEUE_DEPTH),
   localparam int MAW = $clog2(3 * QUEUE_DEPTH)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           req_type,
   input  wire logic [2:0]     priority_level,
   output tlpq_pkg::op_type    op,
   output logic      [MAW-1:0] mem_addr
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int TW = CW + 2;

   localparam logic [SW-1:0]  DepthS    = SW'(QUEUE_DEPTH);
   localparam logic [TW-1:0]  DepthT    = TW'(QUEUE_DEPTH);
   localparam logic [MAW-1:0] MidBase   = MAW'(QUEUE_DEPTH);
   localparam logic [MAW-1:0] NormBase  = MAW'(2 * QUEUE_DEPTH);
   localparam logic [CW-1:0]  CountOne  = CW'(1);
   localparam logic [SW-1:0]  OffsetOne = SW'(1);

   logic [CW-1:0] urgent_count_ff, urgent_count_in;
   logic [AW-1:0] middle_head_ff,  middle_head_in;
   logic [CW-1:0] middle_count_ff, middle_count_in;
   logic [AW-1:0] normal_head_ff,  normal_head_in;
   logic [CW-1:0] normal_count_ff, normal_count_in;

   logic [TW-1:0] total;
   logic          full;
   logic          lvl_valid;

   // Slot of a ring entry: head plus offset, folded once around the depth.
   function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] head,
                                               input logic [SW-1:0] offset);
      logic [SW-1:0] sum;
      sum = SW'(head) + offset;
      if (sum >= DepthS) begin
         sum = sum - DepthS;
      end
      return sum[AW-1:0];
   endfunction

   assign total = TW'(urgent_count_ff) + TW'(middle_count_ff) + TW'(normal_count_ff);
   assign full  = (total >= DepthT);
   assign lvl_valid = (priority_level == tlpq_pkg::LVL_URGENT) ||
                      (priority_level == tlpq_pkg::LVL_MIDDLE) ||
                      (priority_level == tlpq_pkg::LVL_NORMAL);

   // Decide the memory access, status and level for the request beat.
   always_comb begin
      op              = '0;
      mem_addr        = '0;
      urgent_count_in = urgent_count_ff;
      middle_head_in  = middle_head_ff;
      middle_count_in = middle_count_ff;
      normal_head_in  = normal_head_ff;
      normal_count_in = normal_count_ff;

      if (req_type == tlpq_pkg::REQ_INSERT) begin
         if (!lvl_valid) begin
            op.status = tlpq_pkg::ST_INVALID;
         end else if (full) begin
            op.status = tlpq_pkg::ST_FULL;
         end else begin
            op.status = tlpq_pkg::ST_INSERTED;
            op.mem_en = 1'b1;
            op.mem_we = 1'b1;
            case (priority_level)
               tlpq_pkg::LVL_URGENT: begin
                  mem_addr        = MAW'(urgent_count_ff[AW-1:0]);
                  urgent_count_in = urgent_count_ff + CountOne;
               end
               tlpq_pkg::LVL_MIDDLE: begin
                  mem_addr        = MidBase +
                                    MAW'(ring_slot(middle_head_ff, SW'(middle_count_ff)));
                  middle_count_in = middle_count_ff + CountOne;
               end
               default: begin
                  mem_addr        = NormBase +
                                    MAW'(ring_slot(normal_head_ff, SW'(normal_count_ff)));
                  normal_count_in = normal_count_ff + CountOne;
               end
            endcase
         end
      end else begin
         if (urgent_count_ff != '0) begin
            // Urgent entries form a stack: pop the newest one.
            urgent_count_in = urgent_count_ff - CountOne;
            mem_addr        = MAW'(urgent_count_in[AW-1:0]);
            op.mem_en       = 1'b1;
            op.status       = tlpq_pkg::ST_REMOVED;
            op.level        = tlpq_pkg::LVL_URGENT[1:0];
         end else if (middle_count_ff != '0) begin
            mem_addr        = MidBase + MAW'(middle_head_ff);
            middle_head_in  = ring_slot(middle_head_ff, OffsetOne);
            middle_count_in = middle_count_ff - CountOne;
            op.mem_en       = 1'b1;
            op.status       = tlpq_pkg::ST_REMOVED;
            op.level        = tlpq_pkg::LVL_MIDDLE[1:0];
         end else if (normal_count_ff != '0) begin
            mem_addr        = NormBase + MAW'(normal_head_ff);
            normal_head_in  = ring_slot(normal_head_ff, OffsetOne);
            normal_count_in = normal_count_ff - CountOne;
            op.mem_en       = 1'b1;
            op.status       = tlpq_pkg::ST_REMOVED;
            op.level        = tlpq_pkg::LVL_NORMAL[1:0];
         end else begin
            op.status = tlpq_pkg::ST_EMPTY;
         end
      end
   end

   // Counters and heads move only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         urgent_count_ff <= '0;
         middle_head_ff  <= '0;
         middle_count_ff <= '0;
         normal_head_ff  <= '0;
         normal_count_ff <= '0;
      end else if (accept) begin
         urgent_count_ff <= urgent_count_in;
         middle_head_ff  <= middle_head_in;
         middle_count_ff <= middle_count_in;
         normal_head_ff  <= normal_head_in;
         normal_count_ff <= normal_count_in;
      end
   end

   // The three levels together never hold more entries than the queue depth.
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total <= DepthT)
      else $error("queue holds more entries than its depth");

   // A refused or invalid insert leaves every counter untouched.
   a_refused_no_change: assert property (@(posedge clock) disable iff (reset)
      accept && !op.mem_en |=> $stable(total) && $stable(middle_head_ff) &&
                                $stable(normal_head_ff))
      else $error("counters moved on a beat without a memory access");

endmodule

`default_nettype wire
